[rtl/dab_pkg.sv]
`timescale 1ns / 1ps
package dab_pkg;

  localparam int MAX_ROWS   = 128;
  localparam int MAX_COLS   = 128;
  localparam int PIXEL_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int NUM_CH     = 3;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int PLANE   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = ROW_W + COL_W;

  // fixed-point widths of the distance path
  localparam int DIFF_W     = 19;
  localparam int SQ_W       = 36;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int SQ_CNT_W   = $clog2(SQRT_STEPS);
  localparam int COV_W      = FRAC_BITS + 1;
  localparam int PROD_W     = COV_W + PIXEL_BITS;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_DISC  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_COLOR = 2'd2;

  typedef struct packed {
    logic load;
    logic wr_pixel;
    logic rd_capture;
    logic box;
    logic px_diff;
    logic px_square;
    logic sq_init;
    logic sq_step;
    logic cov;
    logic mul;
    logic wb;
  } dab_cmd_t;

  typedef struct packed {
    logic empty;
    logic sq_last;
    logic px_last;
  } dab_stat_t;

endpackage

[rtl/antialiased_disc_blender.sv]
`timescale 1ns / 1ps
// Channel   Handshake                     Payload
// command   start, busy (taken: start&!busy)  cmd, pixel_row .. blue
// result    done (one-cycle strobe)       read_value, done_kind
// config    APB psel/penable/pwrite       paddr, pwdata, prdata
//
// Pixel write: S_WR, S_FIN; pixel read: S_RD1, S_RD2, S_FIN; no-op: S_FIN.
// Disc: S_BOX, S_CHK, then per pixel of the clipped box S_PX0..S_PX2, the
// 18-step bit-serial square root, S_COV, S_MUL, S_WB. All channels of a
// pixel are read, blended and written back in the same pass.
// rst clears the controller and the size/mode registers; the frame
// store holds garbage until written. done cannot be stalled.
module antialiased_disc_blender
  import dab_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [1:0]         cmd,
  input  logic [6:0]         pixel_row,
  input  logic [6:0]         pixel_col,
  input  logic [1:0]         channel,
  input  logic [15:0]        pixel_value,
  input  logic signed [16:0] center_x,
  input  logic signed [16:0] center_y,
  input  logic [15:0]        radius,
  input  logic [15:0]        brightness,
  input  logic [15:0]        red,
  input  logic [15:0]        green,
  input  logic [15:0]        blue,
  output logic [15:0]        read_value,
  output logic [1:0]         done_kind,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]       image_rows;
  logic [7:0]       image_cols;
  logic             color_mode;
  logic [ROW_W-1:0] rows_m1;
  logic [COL_W-1:0] cols_m1;
  dab_cmd_t         ctl;
  dab_stat_t        stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= 8'(MAX_ROWS);
      image_cols <= 8'(MAX_COLS);
      color_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        CFG_ROWS:  image_rows <= pwdata[7:0];
        CFG_COLS:  image_cols <= pwdata[7:0];
        CFG_COLOR: color_mode <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CFG_ROWS:  prdata = {24'b0, image_rows};
      CFG_COLS:  prdata = {24'b0, image_cols};
      CFG_COLOR: prdata = {31'b0, color_mode};
      default:   prdata = '0;
    endcase
  end

  // clamp sizes to 1..MAX and keep the last index
  always_comb begin
    if (image_rows == 8'd0) begin
      rows_m1 = '0;
    end else if (image_rows > 8'(MAX_ROWS)) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(image_rows - 8'd1);
    end
    if (image_cols == 8'd0) begin
      cols_m1 = '0;
    end else if (image_cols > 8'(MAX_COLS)) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(image_cols - 8'd1);
    end
  end

  dab_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  dab_dp u_dp (
    .clk         (clk),
    .ctl         (ctl),
    .stat        (stat),
    .rows_m1     (rows_m1),
    .cols_m1     (cols_m1),
    .color       (color_mode),
    .cmd         (cmd),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .channel     (channel),
    .pixel_value (pixel_value),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .brightness  (brightness),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .read_value  (read_value),
    .done_kind   (done_kind)
  );

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done outside a transaction");
  a_take: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("transaction not taken");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done repeated");
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    done && done_kind != CMD_READ |-> read_value == 16'd0)
    else $error("read_value set on a non-read");
`endif

endmodule

[rtl/dab_ram.sv]
`timescale 1ns / 1ps
module dab_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dab_ctrl.sv]
`timescale 1ns / 1ps
module dab_ctrl
  import dab_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  dab_stat_t  stat,
  output dab_cmd_t   ctl,
  output logic       busy,
  output logic       done
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR   = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_BOX  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_PX0  = 4'd6;
  localparam logic [3:0] S_PX1  = 4'd7;
  localparam logic [3:0] S_PX2  = 4'd8;
  localparam logic [3:0] S_SQ   = 4'd9;
  localparam logic [3:0] S_COV  = 4'd10;
  localparam logic [3:0] S_MUL  = 4'd11;
  localparam logic [3:0] S_WB   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          case (cmd)
            CMD_WRITE: state_next = S_WR;
            CMD_DISC:  state_next = S_BOX;
            CMD_READ:  state_next = S_RD1;
            default:   state_next = S_FIN;
          endcase
        end
      end
      S_WR: begin
        ctl.wr_pixel = 1'b1;
        state_next   = S_FIN;
      end
      S_RD1: state_next = S_RD2;
      S_RD2: begin
        ctl.rd_capture = 1'b1;
        state_next     = S_FIN;
      end
      S_BOX: begin
        ctl.box    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: state_next = stat.empty ? S_FIN : S_PX0;
      S_PX0: begin
        ctl.px_diff = 1'b1;
        state_next  = S_PX1;
      end
      S_PX1: begin
        ctl.px_square = 1'b1;
        state_next    = S_PX2;
      end
      S_PX2: begin
        ctl.sq_init = 1'b1;
        state_next  = S_SQ;
      end
      S_SQ: begin
        ctl.sq_step = 1'b1;
        if (stat.sq_last) begin
          state_next = S_COV;
        end
      end
      S_COV: begin
        ctl.cov    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctl.mul    = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        ctl.wb     = 1'b1;
        state_next = stat.px_last ? S_FIN : S_PX0;
      end
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FIN);

endmodule

[rtl/dab_dp.sv]
`timescale 1ns / 1ps
module dab_dp
  import dab_pkg::*;
(
  input  logic                    clk,
  input  dab_cmd_t                ctl,
  output dab_stat_t               stat,
  input  logic [ROW_W-1:0]        rows_m1,
  input  logic [COL_W-1:0]        cols_m1,
  input  logic                    color,
  input  logic [1:0]              cmd,
  input  logic [6:0]              pixel_row,
  input  logic [6:0]              pixel_col,
  input  logic [1:0]              channel,
  input  logic [15:0]             pixel_value,
  input  logic signed [16:0]      center_x,
  input  logic signed [16:0]      center_y,
  input  logic [15:0]             radius,
  input  logic [15:0]             brightness,
  input  logic [15:0]             red,
  input  logic [15:0]             green,
  input  logic [15:0]             blue,
  output logic [15:0]             read_value,
  output logic [1:0]              done_kind
);

  localparam int BOX_W = 12;

  logic [ROW_W-1:0]        row_q;
  logic [COL_W-1:0]        col_q;
  logic [1:0]              ch_q;
  logic [PIXEL_BITS-1:0]   val_q;
  logic signed [16:0]      cx_q;
  logic signed [16:0]      cy_q;
  logic [15:0]             rad_q;
  logic [PIXEL_BITS-1:0]   tgt_q [NUM_CH];
  logic                    disc_q;

  logic signed [DIFF_W-1:0] yf_q;
  logic [ROW_W-1:0]        r_q;
  logic [COL_W-1:0]        c_q;
  logic [COL_W-1:0]        left_q;
  logic [ROW_W-1:0]        bot_q;
  logic [COL_W-1:0]        right_q;
  logic                    empty_q;

  logic signed [DIFF_W-1:0] dx_q;
  logic signed [DIFF_W-1:0] dy_q;
  logic [SQ_W-1:0]         sx_q;
  logic [SQ_W-1:0]         sy_q;
  logic [SQ_W-1:0]         n_q;
  logic [SQ_W-1:0]         res_q;
  logic [SQ_W-1:0]         bit_q;
  logic [SQ_CNT_W-1:0]     cnt_q;
  logic [COV_W-1:0]        cov_q;
  logic [PROD_W-1:0]       pt_q [NUM_CH];
  logic [PROD_W-1:0]       po_q [NUM_CH];

  logic [PIXEL_BITS-1:0]   rdata [NUM_CH];
  logic [ADDR_W-1:0]       addr;
  logic                    addr_ok;
  logic [PIXEL_BITS-1:0]   rd_sel;

  assign addr_ok = (row_q <= rows_m1) && (col_q <= cols_m1) &&
                   (color ? (ch_q != 2'd3) : (ch_q == 2'd0));
  assign addr    = disc_q ? {r_q, c_q} : {row_q, col_q};

  always_comb begin
    case (ch_q)
      2'd0:    rd_sel = rdata[0];
      2'd1:    rd_sel = rdata[1];
      2'd2:    rd_sel = rdata[2];
      default: rd_sel = '0;
    endcase
  end

  // bounding box; edges and centre in signed whole-pixel units
  logic signed [DIFF_W-1:0] yf_c;
  logic signed [BOX_W-1:0]  row_f, col_f, cr_s;
  logic signed [BOX_W-1:0]  top, bot, left, right;
  logic signed [BOX_W-1:0]  top_c, bot_c, left_c, right_c;
  logic [16:0]              rad_up;

  always_comb begin
    yf_c    = $signed({{(DIFF_W-ROW_W-FRAC_BITS){1'b0}}, rows_m1, {FRAC_BITS{1'b0}}})
              - DIFF_W'(cy_q);
    row_f   = BOX_W'(yf_c >>> FRAC_BITS);
    col_f   = BOX_W'(cx_q >>> FRAC_BITS);
    rad_up  = {1'b0, rad_q} + 17'((1 << FRAC_BITS) - 1);
    cr_s    = $signed(BOX_W'(rad_up >> FRAC_BITS));
    top     = row_f - cr_s - BOX_W'(1);
    bot     = row_f + cr_s + BOX_W'(1);
    left    = col_f - cr_s - BOX_W'(1);
    right   = col_f + cr_s + BOX_W'(1);
    top_c   = (top < 0) ? '0 : top;
    left_c  = (left < 0) ? '0 : left;
    bot_c   = (bot > $signed(BOX_W'(rows_m1))) ? $signed(BOX_W'(rows_m1)) : bot;
    right_c = (right > $signed(BOX_W'(cols_m1))) ? $signed(BOX_W'(cols_m1)) : right;
  end

  // one digit of the integer square root
  logic [SQ_W-1:0] trial;
  assign trial = res_q + bit_q;

  logic signed [DIFF_W+1:0] cov_s;
  assign cov_s = $signed({{(DIFF_W+2-16){1'b0}}, rad_q})
               - $signed({2'b0, res_q[DIFF_W-1:0]})
               + $signed((DIFF_W+2)'(1 << (FRAC_BITS - 1)));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      row_q      <= pixel_row;
      col_q      <= pixel_col;
      ch_q       <= channel;
      val_q      <= pixel_value;
      cx_q       <= center_x;
      cy_q       <= center_y;
      rad_q      <= radius;
      tgt_q[0]   <= color ? red : brightness;
      tgt_q[1]   <= green;
      tgt_q[2]   <= blue;
      disc_q     <= (cmd == CMD_DISC);
      done_kind  <= cmd;
      read_value <= '0;
    end
    if (ctl.rd_capture) begin
      read_value <= addr_ok ? rd_sel : '0;
    end
    if (ctl.box) begin
      yf_q    <= yf_c;
      r_q     <= top_c[ROW_W-1:0];
      c_q     <= left_c[COL_W-1:0];
      left_q  <= left_c[COL_W-1:0];
      bot_q   <= bot_c[ROW_W-1:0];
      right_q <= right_c[COL_W-1:0];
      empty_q <= (top_c > bot_c) || (left_c > right_c);
    end
    if (ctl.px_diff) begin
      dx_q <= $signed({{(DIFF_W-COL_W-FRAC_BITS){1'b0}}, c_q, {FRAC_BITS{1'b0}}})
              - DIFF_W'(cx_q);
      dy_q <= $signed({{(DIFF_W-ROW_W-FRAC_BITS){1'b0}}, r_q, {FRAC_BITS{1'b0}}}) - yf_q;
    end
    if (ctl.px_square) begin
      sx_q <= $unsigned(SQ_W'(dx_q) * SQ_W'(dx_q));
      sy_q <= $unsigned(SQ_W'(dy_q) * SQ_W'(dy_q));
    end
    if (ctl.sq_init) begin
      n_q   <= sx_q + sy_q;
      res_q <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
      cnt_q <= '0;
    end
    if (ctl.sq_step) begin
      if (n_q >= trial) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
      cnt_q <= cnt_q + SQ_CNT_W'(1);
    end
    if (ctl.cov) begin
      if (cov_s < 0) begin
        cov_q <= '0;
      end else if (cov_s > $signed((DIFF_W+2)'(1 << FRAC_BITS))) begin
        cov_q <= COV_W'(1 << FRAC_BITS);
      end else begin
        cov_q <= cov_s[COV_W-1:0];
      end
    end
    if (ctl.wb) begin
      if (c_q == right_q) begin
        c_q <= left_q;
        r_q <= r_q + ROW_W'(1);
      end else begin
        c_q <= c_q + COL_W'(1);
      end
    end
  end

  assign stat.empty   = empty_q;
  assign stat.sq_last = (cnt_q == SQ_CNT_W'(SQRT_STEPS - 1));
  assign stat.px_last = (r_q == bot_q) && (c_q == right_q);

  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
    logic                  we;
    logic [PIXEL_BITS-1:0] wdata;
    logic [PROD_W:0]       acc;

    assign acc   = {1'b0, pt_q[k]} + {1'b0, po_q[k]} + (PROD_W+1)'(1 << (FRAC_BITS - 1));
    assign we    = (ctl.wb && (k == 0 || color)) ||
                   (ctl.wr_pixel && addr_ok && (ch_q == 2'(k)));
    assign wdata = ctl.wb ? acc[FRAC_BITS +: PIXEL_BITS] : val_q;

    always_ff @(posedge clk) begin
      if (ctl.mul) begin
        pt_q[k] <= cov_q * tgt_q[k];
        po_q[k] <= (COV_W'(1 << FRAC_BITS) - cov_q) * rdata[k];
      end
    end

    dab_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (PLANE)
    ) u_plane (
      .clk   (clk),
      .we    (we),
      .waddr (addr),
      .wdata (wdata),
      .raddr (addr),
      .rdata (rdata[k])
    );
  end

endmodule
